@@ rtl/tftg_pkg.sv @@
`timescale 1ns / 1ps

package tftg_pkg;

  // Gait resolution: one phase has STEPS + 1 step positions
  localparam int STEPS  = 80;
  localparam int STEP_W = $clog2(STEPS + 1);

  // Job queue between front and back (depth must be a power of two)
  localparam int QUEUE_DEPTH = 4;
  localparam int QPTR_W      = $clog2(QUEUE_DEPTH);

  localparam int CFG_IDX_W  = 3;
  localparam int CFG_DATA_W = 16;

  // Shared multiplier
  localparam int MUL_A_W = 30;
  localparam int MUL_B_W = 22;
  localparam int PROD_W  = 52;

  // Stance offset divide by 2*STEPS*4096, done as reciprocal multiply
  localparam int DY_DIV   = 2 * STEPS;
  localparam int DY_HALF  = STEPS * 4096;
  localparam int DY_SHIFT = 12;
  localparam int DY_K     = 25;
  localparam int DY_RECIP = (1 << DY_K) / DY_DIV;
  localparam int VQ_W     = 25;
  localparam int Q_W      = 18;

  typedef enum logic [1:0] {
    CMD_TICK  = 2'd0,
    CMD_START = 2'd1,
    CMD_STOP  = 2'd2,
    CMD_NONE  = 2'd3
  } cmd_t;

  typedef enum logic [CFG_IDX_W-1:0] {
    REG_STRIDE = 3'd0,
    REG_LIFT   = 3'd1,
    REG_BODY   = 3'd2,
    REG_LEAN   = 3'd3,
    REG_VFWD   = 3'd4,
    REG_VSIDE  = 3'd5
  } cfg_reg_t;

  typedef struct packed {
    logic [1:0] command;
    logic [7:0] cycle_count;
    logic       robot_standing;
  } in_t;

  typedef struct packed {
    logic [2:0]         leg_number;
    logic signed [15:0] foot_x;
    logic signed [15:0] foot_y;
    logic signed [15:0] foot_z;
    logic               swinging;
    logic               last_of_tick;
  } out_t;

  typedef struct packed {
    logic [13:0]        stride_length;
    logic [13:0]        lift_height;
    logic [13:0]        body_height;
    logic signed [15:0] lean_gain;
    logic signed [15:0] velocity_forward;
    logic signed [15:0] velocity_side;
  } cfg_t;

  localparam cfg_t CFG_RESET = '{
    stride_length:    14'd2048,
    lift_height:      14'd1536,
    body_height:      14'd6144,
    lean_gain:        16'sd205,
    velocity_forward: 16'sd4915,
    velocity_side:    16'sd0
  };

  typedef struct packed {
    logic [STEP_W-1:0] step;
    logic              second_phase;
  } job_t;

  typedef struct packed {
    logic signed [17:0] p17;
    logic [14:0]        sn;
  } rom_entry_t;

  // ---------------------------------------------------------------
  // Per-step swing table, evaluated at elaboration
  // ---------------------------------------------------------------
  localparam longint unsigned PI_Q30  = 64'd3373259426;
  localparam longint unsigned D2      = 2 * STEPS;
  localparam longint unsigned D3      = 3 * STEPS;
  localparam longint unsigned D2_CUBE = D2 * D2 * D2;
  localparam longint unsigned D3_CUBE = D3 * D3 * D3;

  function automatic longint unsigned series_mul(input longint unsigned term,
                                                 input longint unsigned x2);
    return (term * x2 + (64'd1 << 29)) >> 30;
  endfunction

  // sin(x) for x in Q30, odd series to x^15, result Q14 clamped to [0, 1]
  function automatic longint sine_series(input longint unsigned x);
    longint unsigned x2;
    longint unsigned term;
    longint          sum;
    x2   = (x * x + (64'd1 << 29)) >> 30;
    term = x;
    sum  = longint'(x);
    term = (series_mul(term, x2) + 64'd3) / 64'd6;
    sum  = sum - longint'(term);
    term = (series_mul(term, x2) + 64'd10) / 64'd20;
    sum  = sum + longint'(term);
    term = (series_mul(term, x2) + 64'd21) / 64'd42;
    sum  = sum - longint'(term);
    term = (series_mul(term, x2) + 64'd36) / 64'd72;
    sum  = sum + longint'(term);
    term = (series_mul(term, x2) + 64'd55) / 64'd110;
    sum  = sum - longint'(term);
    term = (series_mul(term, x2) + 64'd78) / 64'd156;
    sum  = sum + longint'(term);
    term = (series_mul(term, x2) + 64'd105) / 64'd210;
    sum  = sum - longint'(term);
    if (sum < 0) begin
      sum = -((-sum + 32768) >>> 16);
    end else begin
      sum = (sum + 32768) >>> 16;
    end
    if (sum < 0) begin
      sum = 0;
    end
    if (sum > 16384) begin
      sum = 16384;
    end
    return sum;
  endfunction

  function automatic rom_entry_t swing_rom(input int s);
    longint unsigned n;
    longint unsigned num;
    longint unsigned xv;
    longint          p;
    longint          sn_v;
    rom_entry_t      e;
    if (longint'(5 * s) <= longint'(D2)) begin
      n   = longint'(5 * s);
      num = n * n * (3 * D2 - 2 * n);
      p   = 2 * longint'((num * 65536 + D2_CUBE / 2) / D2_CUBE) - 65536;
      if (2 * n > D2) begin
        n = D2 - n;
      end
      xv   = (PI_Q30 * n + D2 / 2) / D2;
      sn_v = sine_series(xv);
    end else begin
      n   = longint'(5 * s) - D2;
      num = n * n * (3 * D3 - 2 * n);
      p   = longint'((num * 65536 + D3_CUBE / 2) / D3_CUBE);
      n   = longint'(5 * (STEPS - s));
      if (2 * n > D3) begin
        n = D3 - n;
      end
      xv   = (PI_Q30 * n + D3 / 2) / D3;
      sn_v = sine_series(xv);
    end
    e.p17 = 18'(p);
    e.sn  = 15'(sn_v);
    return e;
  endfunction

  // ---------------------------------------------------------------
  // Datapath helpers
  // ---------------------------------------------------------------

  // Round to nearest, ties away from zero, after a right shift by n
  function automatic logic signed [PROD_W-1:0] round_shr(input logic signed [PROD_W-1:0] v,
                                                         input int unsigned n);
    logic [PROD_W-1:0] mag;
    logic [PROD_W-1:0] q;
    mag = v[PROD_W-1] ? PROD_W'(-v) : PROD_W'(v);
    q   = (mag + (PROD_W'(1) << (n - 1))) >> n;
    return v[PROD_W-1] ? $signed(PROD_W'(-q)) : $signed(q);
  endfunction

  function automatic logic signed [15:0] sat16(input logic signed [18:0] v);
    if (v > 19'sd32767) begin
      return 16'sh7FFF;
    end else if (v < -19'sd32768) begin
      return 16'sh8000;
    end else begin
      return v[15:0];
    end
  endfunction

  // Word k of a tick: k 0..2 swing group, 3..5 stance group, ascending legs.
  // Group A = legs 1,4,5, group B = legs 2,3,6; phase A swings group A.
  function automatic logic [2:0] leg_sel(input logic second_phase, input logic [2:0] k);
    logic       use_a;
    logic [2:0] idx;
    logic [2:0] leg;
    use_a = (k < 3'd3) ^ second_phase;
    idx   = (k < 3'd3) ? k : 3'(k - 3'd3);
    unique case (idx)
      3'd0:    leg = use_a ? 3'd1 : 3'd2;
      3'd1:    leg = use_a ? 3'd4 : 3'd3;
      3'd2:    leg = use_a ? 3'd5 : 3'd6;
      default: leg = 3'd1;
    endcase
    return leg;
  endfunction

  function automatic logic signed [15:0] base_x(input logic [2:0] leg);
    logic signed [15:0] v;
    unique case (leg)
      3'd1:    v = 16'sd5120;
      3'd2:    v = -16'sd5120;
      3'd3:    v = 16'sd6400;
      3'd4:    v = -16'sd6400;
      3'd5:    v = 16'sd5120;
      3'd6:    v = -16'sd5120;
      default: v = 16'sd0;
    endcase
    return v;
  endfunction

  function automatic logic signed [15:0] base_y(input logic [2:0] leg);
    logic signed [15:0] v;
    unique case (leg)
      3'd1, 3'd2: v = -16'sd4608;
      3'd5, 3'd6: v = 16'sd4608;
      default:    v = 16'sd0;
    endcase
    return v;
  endfunction

endpackage

@@ rtl/tftg_front.sv @@
`timescale 1ns / 1ps

module tftg_front (
  input  logic           clk,
  input  logic           rst,
  input  logic           in_valid,
  output logic           in_ready,
  input  tftg_pkg::in_t  in_word,
  output logic           push_valid,
  input  logic           push_ready,
  output tftg_pkg::job_t push_data
);
  import tftg_pkg::*;

  logic              walking;
  logic              in_cycle;
  logic [7:0]        cycles_left;
  logic              second_phase;
  logic [STEP_W-1:0] step_index;

  logic              accept;
  logic              can_run;
  logic [STEP_W-1:0] cur_step;
  logic              cur_phase;

  always_comb begin
    accept     = in_valid && in_ready;
    can_run    = in_cycle || (walking && (cycles_left != 8'd0));
    cur_step   = in_cycle ? step_index : '0;
    cur_phase  = in_cycle ? second_phase : 1'b0;
    in_ready   = push_ready;
    push_valid = in_valid && push_ready && (in_word.command == CMD_TICK) && can_run;
    push_data  = '{step: cur_step, second_phase: cur_phase};
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      walking      <= 1'b0;
      in_cycle     <= 1'b0;
      cycles_left  <= 8'd0;
      second_phase <= 1'b0;
      step_index   <= '0;
    end else if (accept) begin
      unique case (in_word.command)
        CMD_START: begin
          if (in_word.robot_standing) begin
            walking     <= 1'b1;
            cycles_left <= in_word.cycle_count;
          end
        end
        CMD_STOP: begin
          walking     <= 1'b0;
          cycles_left <= 8'd0;
        end
        CMD_TICK: begin
          if (!can_run) begin
            walking <= 1'b0;
          end else begin
            if (!in_cycle) begin
              cycles_left <= 8'(cycles_left - 8'd1);
            end
            in_cycle <= 1'b1;
            if (cur_step == STEP_W'(STEPS)) begin
              step_index <= '0;
              if (cur_phase) begin
                second_phase <= 1'b0;
                in_cycle     <= 1'b0;
              end else begin
                second_phase <= 1'b1;
              end
            end else begin
              step_index   <= STEP_W'(cur_step + 1'b1);
              second_phase <= cur_phase;
            end
          end
        end
        default: ;
      endcase
    end
  end

endmodule

@@ rtl/tftg_queue.sv @@
`timescale 1ns / 1ps

module tftg_queue (
  input  logic           clk,
  input  logic           rst,
  input  logic           push_valid,
  output logic           push_ready,
  input  tftg_pkg::job_t push_data,
  output logic           pop_valid,
  input  logic           pop_ready,
  output tftg_pkg::job_t pop_data
);
  import tftg_pkg::*;

  job_t              slots [QUEUE_DEPTH];
  logic [QPTR_W-1:0] wr_ptr;
  logic [QPTR_W-1:0] rd_ptr;
  logic [QPTR_W:0]   count;
  logic              do_push;
  logic              do_pop;

  always_comb begin
    push_ready = (count != (QPTR_W + 1)'(QUEUE_DEPTH));
    pop_valid  = (count != '0);
    pop_data   = slots[rd_ptr];
    do_push    = push_valid && push_ready;
    do_pop     = pop_valid && pop_ready;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (do_push) begin
        wr_ptr <= QPTR_W'(wr_ptr + 1'b1);
      end
      if (do_pop) begin
        rd_ptr <= QPTR_W'(rd_ptr + 1'b1);
      end
      if (do_push && !do_pop) begin
        count <= (QPTR_W + 1)'(count + 1'b1);
      end else if (do_pop && !do_push) begin
        count <= (QPTR_W + 1)'(count - 1'b1);
      end
    end
  end

  always_ff @(posedge clk) begin
    if (do_push) begin
      slots[wr_ptr] <= push_data;
    end
  end

endmodule

@@ rtl/tftg_back.sv @@
`timescale 1ns / 1ps

module tftg_back (
  input  logic           clk,
  input  logic           rst,
  input  tftg_pkg::cfg_t cfg,
  input  logic           job_valid,
  output logic           job_ready,
  input  tftg_pkg::job_t job_in,
  output logic           out_valid,
  input  logic           out_ready,
  output tftg_pkg::out_t out_word
);
  import tftg_pkg::*;

  typedef enum logic [2:0] {
    B_IDLE = 3'b001,
    B_CALC = 3'b010,
    B_EMIT = 3'b100
  } back_state_t;

  // Calculation steps: at most one multiply issued per step, product used next step
  localparam logic [3:0] ST_F    = 4'd0;
  localparam logic [3:0] ST_G    = 4'd1;
  localparam logic [3:0] ST_L    = 4'd2;
  localparam logic [3:0] ST_LIFT = 4'd3;
  localparam logic [3:0] ST_GP   = 4'd4;
  localparam logic [3:0] ST_FP   = 4'd5;
  localparam logic [3:0] ST_FD   = 4'd6;
  localparam logic [3:0] ST_VQ   = 4'd7;
  localparam logic [3:0] ST_REC  = 4'd8;
  localparam logic [3:0] ST_Q0   = 4'd9;
  localparam logic [3:0] ST_QD   = 4'd10;
  localparam logic [3:0] ST_DY   = 4'd11;

  localparam logic [2:0] LAST_K = 3'd5;

  back_state_t state;
  logic [3:0]  step;
  logic [2:0]  k;

  rom_entry_t rom [0:STEPS];
  for (genvar i = 0; i <= STEPS; i++) begin : g_rom
    localparam rom_entry_t ROM_E = swing_rom(i);
    assign rom[i] = ROM_E;
  end

  job_t               job;
  rom_entry_t         rom_q;
  logic signed [MUL_A_W-1:0] mul_a;
  logic signed [MUL_B_W-1:0] mul_b;
  logic signed [PROD_W-1:0]  mul_p;
  logic signed [PROD_W-1:0]  prod;

  logic signed [29:0] f;
  logic signed [29:0] g;
  logic signed [31:0] lean_l;
  logic signed [15:0] lift_q;
  logic signed [17:0] z5;
  logic signed [17:0] z3;
  logic signed [17:0] gp;
  logic signed [17:0] fp;
  logic signed [18:0] swz;
  logic signed [18:0] stz;
  logic               neg;
  logic [VQ_W-1:0]    vq;
  logic [Q_W-1:0]     q0;
  logic signed [18:0] dy;

  logic signed [STEP_W+1:0] dsig;
  logic signed [34:0]       l5;
  logic signed [34:0]       l3;
  logic [PROD_W-1:0]        prod_mag;
  logic [PROD_W-1:0]        vq_sum;
  logic [VQ_W:0]            rem;
  logic [18:0]              dy_mag;

  logic               is_swing;
  logic [2:0]         leg;
  logic signed [18:0] x_sum;
  logic signed [18:0] y_sum;
  logic signed [18:0] z_sum;
  out_t               word_next;
  logic               load_out;

  assign mul_p = mul_a * mul_b;

  always_comb begin
    dsig     = $signed({1'b0, job.step, 1'b0}) - (STEP_W + 2)'(STEPS);
    l5       = (35'(lean_l) <<< 2) + 35'(lean_l);
    l3       = (35'(lean_l) <<< 1) + 35'(lean_l);
    prod_mag = prod[PROD_W-1] ? PROD_W'(-prod) : PROD_W'(prod);
    vq_sum   = prod_mag + PROD_W'(DY_HALF);
    rem      = {1'b0, vq} - prod[VQ_W:0];
    dy_mag   = 19'(q0) + 19'(rem >= (VQ_W + 1)'(DY_DIV));
  end

  always_comb begin
    mul_a = '0;
    mul_b = '0;
    unique case (step)
      ST_F: begin
        mul_a = MUL_A_W'(cfg.stride_length);
        mul_b = MUL_B_W'(cfg.velocity_forward);
      end
      ST_G: begin
        mul_a = MUL_A_W'(cfg.stride_length);
        mul_b = MUL_B_W'(cfg.velocity_side);
      end
      ST_L: begin
        mul_a = MUL_A_W'(cfg.lean_gain);
        mul_b = MUL_B_W'(cfg.velocity_forward);
      end
      ST_LIFT: begin
        mul_a = MUL_A_W'(cfg.lift_height);
        mul_b = MUL_B_W'(rom_q.sn);
      end
      ST_GP: begin
        mul_a = g;
        mul_b = MUL_B_W'(rom_q.p17);
      end
      ST_FP: begin
        mul_a = f;
        mul_b = MUL_B_W'(rom_q.p17);
      end
      ST_FD: begin
        mul_a = f;
        mul_b = MUL_B_W'(dsig);
      end
      ST_REC: begin
        mul_a = MUL_A_W'(vq);
        mul_b = MUL_B_W'(DY_RECIP);
      end
      ST_QD: begin
        mul_a = MUL_A_W'(q0);
        mul_b = MUL_B_W'(DY_DIV);
      end
      default: ;
    endcase
  end

  // Output word k of the current tick
  always_comb begin
    is_swing = (k < 3'd3);
    leg      = leg_sel(job.second_phase, k);
    if (is_swing) begin
      x_sum = 19'(base_x(leg)) + 19'(gp);
      y_sum = 19'(base_y(leg)) + 19'(fp);
      z_sum = swz;
    end else begin
      x_sum = 19'(base_x(leg));
      y_sum = 19'(base_y(leg)) - dy;
      z_sum = stz;
    end
    word_next = '{
      leg_number:   leg,
      foot_x:       sat16(x_sum),
      foot_y:       sat16(y_sum),
      foot_z:       sat16(z_sum),
      swinging:     is_swing,
      last_of_tick: (k == LAST_K)
    };
    job_ready = (state == B_IDLE);
    load_out  = (state == B_EMIT) && (!out_valid || out_ready);
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= B_IDLE;
      step      <= ST_F;
      k         <= '0;
      out_valid <= 1'b0;
    end else begin
      if (load_out) begin
        out_valid <= 1'b1;
      end else if (out_ready) begin
        out_valid <= 1'b0;
      end
      unique case (state)
        B_IDLE: begin
          if (job_valid) begin
            state <= B_CALC;
            step  <= ST_F;
          end
        end
        B_CALC: begin
          if (step == ST_DY) begin
            state <= B_EMIT;
            k     <= '0;
          end else begin
            step <= 4'(step + 1'b1);
          end
        end
        B_EMIT: begin
          if (load_out) begin
            k <= 3'(k + 1'b1);
            if (k == LAST_K) begin
              state <= B_IDLE;
            end
          end
        end
        default: state <= B_IDLE;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    prod <= mul_p;
    if (state == B_IDLE && job_valid) begin
      job   <= job_in;
      rom_q <= rom[job_in.step];
    end
    if (load_out) begin
      out_word <= word_next;
    end
    if (state == B_CALC) begin
      unique case (step)
        ST_G:    f <= prod[29:0];
        ST_L:    g <= prod[29:0];
        ST_LIFT: lean_l <= prod[31:0];
        ST_GP: begin
          lift_q <= 16'(round_shr(prod, 14));
          z5     <= 18'(round_shr(PROD_W'(l5), 16));
        end
        ST_FP: begin
          gp <= 18'(round_shr(prod, 29));
          z3 <= 18'(round_shr(PROD_W'(l3), 16));
        end
        ST_FD: begin
          fp  <= 18'(round_shr(prod, 29));
          swz <= 19'(z5) - 19'(lift_q) - $signed(19'(cfg.body_height));
        end
        ST_VQ: begin
          neg <= prod[PROD_W-1];
          vq  <= vq_sum[DY_SHIFT +: VQ_W];
          stz <= 19'(z3) - $signed(19'(cfg.body_height));
        end
        ST_Q0:   q0 <= prod[DY_K +: Q_W];
        ST_DY:   dy <= neg ? $signed(19'(-dy_mag)) : $signed(dy_mag);
        default: ;
      endcase
    end
  end

endmodule

@@ rtl/tripod_foot_trajectory_generator.sv @@
`timescale 1ns / 1ps

// Tripod gait foot-target generator.
// Input channel (in_valid/in_ready/in_word): one command word per handshake:
// tick, start (with cycle count, only taken when standing) or stop. The front
// end updates the gait state at once and queues a job for each tick that
// emits; start, stop and idle ticks produce nothing.
// Output channel (out_valid/out_ready/out_word): six words per emitting tick,
// the three swing legs then the three stance legs; last_of_tick marks word six.
// Config port: cfg_we writes cfg_data to register cfg_index (0 stride,
// 1 lift, 2 body height, 3 lean gain, 4 forward velocity, 5 side velocity);
// other indexes are dropped. Write only while no tick is in flight.
// Flow: the back end works one tick at a time: it takes the job while idle,
// runs the calculation steps on its single shared multiplier, then emits the
// six output words, and takes no new job until the sixth word is loaded. A
// 4-entry job queue lets the input keep taking commands while the back end is
// busy; in_ready drops only when the queue is full. A stalled receiver holds
// the output word and pauses the back end. Synchronous reset restores the
// default registers and a standing, non-walking gait state; no clearing pass
// is needed.
module tripod_foot_trajectory_generator (
  input  logic                              clk,
  input  logic                              rst,
  input  logic                              in_valid,
  output logic                              in_ready,
  input  tftg_pkg::in_t                     in_word,
  output logic                              out_valid,
  input  logic                              out_ready,
  output tftg_pkg::out_t                    out_word,
  input  logic                              cfg_we,
  input  logic [tftg_pkg::CFG_IDX_W-1:0]    cfg_index,
  input  logic [tftg_pkg::CFG_DATA_W-1:0]   cfg_data
);
  import tftg_pkg::*;

  cfg_t cfg;
  logic push_valid;
  logic push_ready;
  job_t push_data;
  logic pop_valid;
  logic pop_ready;
  job_t pop_data;

  always_ff @(posedge clk) begin
    if (rst) begin
      cfg <= CFG_RESET;
    end else if (cfg_we) begin
      unique case (cfg_index)
        REG_STRIDE: cfg.stride_length    <= cfg_data[13:0];
        REG_LIFT:   cfg.lift_height      <= cfg_data[13:0];
        REG_BODY:   cfg.body_height      <= cfg_data[13:0];
        REG_LEAN:   cfg.lean_gain        <= cfg_data;
        REG_VFWD:   cfg.velocity_forward <= cfg_data;
        REG_VSIDE:  cfg.velocity_side    <= cfg_data;
        default: ;
      endcase
    end
  end

  tftg_front u_front (
    .clk        (clk),
    .rst        (rst),
    .in_valid   (in_valid),
    .in_ready   (in_ready),
    .in_word    (in_word),
    .push_valid (push_valid),
    .push_ready (push_ready),
    .push_data  (push_data)
  );

  tftg_queue u_queue (
    .clk        (clk),
    .rst        (rst),
    .push_valid (push_valid),
    .push_ready (push_ready),
    .push_data  (push_data),
    .pop_valid  (pop_valid),
    .pop_ready  (pop_ready),
    .pop_data   (pop_data)
  );

  tftg_back u_back (
    .clk       (clk),
    .rst       (rst),
    .cfg       (cfg),
    .job_valid (pop_valid),
    .job_ready (pop_ready),
    .job_in    (pop_data),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .out_word  (out_word)
  );

  // Only ticks enqueue work
  a_only_tick_pushes: assert property (@(posedge clk) disable iff (rst)
    push_valid |-> (in_valid && in_word.command == CMD_TICK))
    else $error("job queued for a non-tick command");

  a_push_has_room: assert property (@(posedge clk) disable iff (rst)
    push_valid |-> push_ready)
    else $error("job pushed into a full queue");

  a_reset_quiet: assert property (@(posedge clk)
    rst |=> !out_valid)
    else $error("output valid right after reset");

  // The sixth word of a tick is always a stance leg
  a_last_is_stance: assert property (@(posedge clk) disable iff (rst)
    (out_valid && out_word.last_of_tick) |-> !out_word.swinging)
    else $error("last word of tick marked as swing");

endmodule
